>>> rtl/core/assert_macros.svh
// Assertion macros shared by the arc sampler RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define AST_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/core/cas_pkg.sv
// Types and constants for the circular arc sampler.
// No dependencies.
package cas_pkg;
  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
  localparam logic signed [42:0] OUT_LIMIT = 43'sd16777215;

  typedef enum logic [1:0] {
    FR_IDLE, FR_DIV, FR_CNT, FR_PUSH
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_RED, BK_ROT, BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [23:0]        radius;
    logic signed [31:0] offset;
    logic signed [31:0] sstep;
    logic [6:0]         count;
  } arc_job_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd210828714;
      5'd1: v = 34'sd124459457;
      5'd2: v = 34'sd65760959;
      5'd3: v = 34'sd33381290;
      5'd4: v = 34'sd16755422;
      5'd5: v = 34'sd8385879;
      5'd6: v = 34'sd4193963;
      5'd7: v = 34'sd2097109;
      5'd8: v = 34'sd1048571;
      5'd9: v = 34'sd524287;
      default: v = (i < 5'd29) ? (34'sd268435456 >>> i) : 34'sd0;
    endcase
    return v;
  endfunction
endpackage

>>> rtl/core/cas_front.sv
// Front end: checks a request, divides out the angular step and point count.
// Depends on cas_pkg.
module cas_front #(
  parameter int MAX_POINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       step_cfg,
  input  logic              in_push,
  output logic              in_full,
  input  logic [23:0]       in_radius,
  input  logic signed [31:0] in_angular_displacement,
  input  logic signed [31:0] in_angular_offset,
  output logic              job_push,
  output cas_pkg::arc_job_t job_data,
  input  logic              job_full
);
  import cas_pkg::*;

  fr_state_t state_r, state_nxt;
  logic [23:0] rad_r;
  logic signed [31:0] disp_r, offs_r;
  logic [52:0] num_r;
  logic [52:0] quo_r;
  logic [24:0] rem_r;
  logic [5:0]  bit_r;
  logic [31:0] step_r;
  logic [32:0] mag_r;
  logic [6:0]  cnt_r;

  logic [24:0] rem_sh, rem_sub;
  logic        ge;
  logic [53:0] quo_sh;
  logic [32:0] step_rnd;
  logic [33:0] num2;
  logic [32:0] den2;
  logic signed [31:0] sstep;
  logic accept, bad;
  logic [2:0]  cbit;
  logic [39:0] trial;
  logic        cnt_ge, cnt_sat;

  assign accept = in_push && !in_full;
  assign bad = (in_radius == 24'd0) || (in_angular_displacement == 32'sd0) ||
               (step_cfg == 24'd0);
  assign rem_sh = {rem_r[23:0], num_r[52]};
  assign ge = rem_sh >= {1'b0, rad_r};
  assign rem_sub = ge ? rem_sh - {1'b0, rad_r} : rem_sh;
  assign quo_sh = {quo_r, ge};
  assign step_rnd = ({1'b0, quo_r[31:0]} + 33'd1) >> 1;
  assign den2 = {step_r, 1'b0};
  assign num2 = {mag_r, 1'b0} + {2'b0, step_r};
  assign sstep = disp_r[31] ? -step_r : step_r;
  assign cbit = 3'(6'd7 - bit_r);
  assign trial = {7'd0, den2} << cbit;
  assign cnt_ge = num_r >= {13'd0, trial};
  assign cnt_sat = {6'd0, num2} >= {1'b0, den2, 6'd0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (accept && !bad) state_nxt = FR_DIV;
      FR_DIV: if (bit_r == 6'd0) state_nxt = FR_CNT;
      FR_CNT: if (bit_r == 6'd8) state_nxt = FR_PUSH;
      FR_PUSH: if (!job_full || cnt_r == 7'd0) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_full = state_r != FR_IDLE;
    job_push = (state_r == FR_PUSH) && (cnt_r != 7'd0) && !job_full;
    job_data.radius = rad_r;
    job_data.offset = offs_r;
    job_data.sstep = sstep;
    job_data.count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FR_IDLE: begin
        rad_r <= in_radius;
        disp_r <= in_angular_displacement;
        offs_r <= in_angular_offset;
        num_r <= {step_cfg, 29'd0};
        quo_r <= '0;
        rem_r <= '0;
        bit_r <= 6'd52;
        mag_r <= in_angular_displacement[31] ?
                 33'd0 - {in_angular_displacement[31], in_angular_displacement} :
                 {1'b0, in_angular_displacement};
      end
      FR_DIV: begin
        rem_r <= rem_sub;
        quo_r <= quo_sh[52:0];
        num_r <= {num_r[51:0], 1'b0};
        if (bit_r != 6'd0) bit_r <= bit_r - 6'd1;
        else begin
          bit_r <= 6'd0;
          cnt_r <= '0;
        end
      end
      FR_CNT: begin
        case (bit_r)
          6'd0: begin
            step_r <= (quo_r[52:32] != '0 || step_rnd > 33'h07FFFFFFF) ? 32'h7FFFFFFF :
                      step_rnd[31:0];
            bit_r <= 6'd1;
          end
          6'd1: begin
            if (step_r == 32'd0) begin
              cnt_r <= '0;
              bit_r <= 6'd8;
            end else if (cnt_sat) begin
              cnt_r <= 7'd64;
              bit_r <= 6'd8;
            end else begin
              num_r <= {19'd0, num2};
              cnt_r <= '0;
              bit_r <= 6'd2;
            end
          end
          6'd8: begin
            if (cnt_r > 7'(MAX_POINTS)) cnt_r <= 7'(MAX_POINTS);
          end
          default: begin
            if (cnt_ge) begin
              num_r <= num_r - {13'd0, trial};
              cnt_r <= cnt_r | (7'd1 << cbit);
            end
            bit_r <= bit_r + 6'd1;
          end
        endcase
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/core/cas_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on cas_pkg and assert_macros.svh.
module cas_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  cas_pkg::arc_job_t wdata,
  output logic              full,
  input  logic              rd,
  output cas_pkg::arc_job_t rdata,
  output logic              empty
);
  import cas_pkg::*;
  arc_job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= !wp_r;
      if (rd && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  `include "assert_macros.svh"
  `AST_IMP(a_no_over, clk, rst_n, full, !(cnt_r == 2'd3))
  `AST_NXT(a_fill, clk, rst_n, wr && !full && !rd, !empty)
  `AST_NXT(a_drain, clk, rst_n, rd && !empty && !wr && cnt_r == 2'd1, empty)
endmodule

>>> rtl/core/cas_back.sv
// Back end: reduces each sample angle and runs an iterative CORDIC rotation.
// Depends on cas_pkg and assert_macros.svh.
module cas_back #(
  parameter int MAX_POINTS = 64,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  input  cas_pkg::arc_job_t  job_data,
  output logic               job_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [24:0] out_point_x,
  output logic signed [24:0] out_point_y,
  output logic [5:0]         out_sample_index,
  output logic               out_last
);
  import cas_pkg::*;

  bk_state_t state_r, state_nxt;
  logic signed [38:0] ang_r;
  logic signed [38:0] base_r;
  logic [6:0]  idx_r;
  logic signed [42:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [4:0]  it_r;
  logic        neg_r;
  logic [2:0]  red_r;
  logic        ov_r;
  logic signed [24:0] ox_r, oy_r;
  logic [5:0]  oi_r;
  logic        ol_r;

  logic signed [42:0] dx, dy, xr, yr, xf, yf;
  logic [53:0] prod;
  logic ov_free;

  assign prod = job_data.radius * CORDIC_GAIN_Q30;
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign xr = (x_r + 43'sd8192) >>> 14;
  assign yr = (y_r + 43'sd8192) >>> 14;
  assign xf = neg_r ? -xr : xr;
  assign yf = neg_r ? -yr : yr;
  assign ov_free = !ov_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!job_empty) state_nxt = BK_RED;
      BK_RED: if (red_r == 3'd4) state_nxt = BK_ROT;
      BK_ROT: if (it_r == 5'(CORDIC_ITERATIONS - 1)) state_nxt = BK_OUT;
      BK_OUT: if (ov_free) state_nxt = (idx_r + 7'd1 == job_data.count) ? BK_IDLE : BK_RED;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (state_r == BK_OUT) && ov_free && (idx_r + 7'd1 == job_data.count);
    out_empty = !ov_r;
    out_point_x = ox_r;
    out_point_y = oy_r;
    out_sample_index = oi_r;
    out_last = ol_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_OUT && ov_free) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        idx_r <= '0;
        ang_r <= 39'(job_data.offset);
        base_r <= 39'(job_data.offset);
        red_r <= '0;
      end
      BK_RED: begin
        red_r <= red_r + 3'd1;
        case (red_r)
          3'd0: begin
            if (ang_r < 0) ang_r <= ang_r + 39'(ANG_TWO_PI) * 4;
          end
          3'd1: begin
            if (ang_r >= 39'(ANG_TWO_PI) * 2) ang_r <= ang_r - 39'(ANG_TWO_PI) * 2;
          end
          3'd2: begin
            if (ang_r >= 39'(ANG_TWO_PI)) ang_r <= ang_r - 39'(ANG_TWO_PI);
          end
          3'd3: begin
            if (ang_r > 39'(ANG_PI)) ang_r <= ang_r - 39'(ANG_TWO_PI);
          end
          default: begin
            z_r <= (ang_r > 39'(ANG_HALF_PI)) ? 34'(ang_r - 39'(ANG_PI)) :
                   (ang_r < -39'(ANG_HALF_PI)) ? 34'(ang_r + 39'(ANG_PI)) : 34'(ang_r);
            neg_r <= (ang_r > 39'(ANG_HALF_PI)) || (ang_r < -39'(ANG_HALF_PI));
            x_r <= 43'(prod >> 16);
            y_r <= '0;
            it_r <= '0;
            red_r <= '0;
          end
        endcase
      end
      BK_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_entry(it_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_entry(it_r);
        end
        if (it_r != 5'(CORDIC_ITERATIONS - 1)) it_r <= it_r + 5'd1;
      end
      BK_OUT: if (ov_free) begin
        ox_r <= 25'((xf > OUT_LIMIT) ? OUT_LIMIT : (xf < -OUT_LIMIT) ? -OUT_LIMIT : xf);
        oy_r <= 25'((yf > OUT_LIMIT) ? OUT_LIMIT : (yf < -OUT_LIMIT) ? -OUT_LIMIT : yf);
        oi_r <= idx_r[5:0];
        ol_r <= idx_r + 7'd1 == job_data.count;
        idx_r <= idx_r + 7'd1;
        base_r <= base_r + 39'(job_data.sstep);
        ang_r <= base_r + 39'(job_data.sstep);
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `AST_IMP(a_pop_busy, clk, rst_n, job_pop, !job_empty)
  `AST_IMP(a_idx_rng, clk, rst_n, state_r == BK_OUT, idx_r < 7'(MAX_POINTS))
  `AST_NXT(a_hold, clk, rst_n, ov_r && !out_pop, ov_r)
endmodule

>>> rtl/core/circular_arc_sampler.sv
// Top level of the circular arc sampler: front end, job queue, back end.
// Depends on cas_pkg, cas_front, cas_queue and cas_back.
// Each request that can yield points holds the input while the front end runs
// a bit-serial 53-step division for the angular step, then a short serial
// division for the count, and longer while the job queue is full; a request
// with zero radius, sweep or step is dropped without holding the input. Each
// sample then passes through angle reduction, the back end's single iterative
// CORDIC and an output step that waits while the last result is unread. Requests
// that yield no points produce no results. A two-entry queue lets the front end
// prepare the next arc while samples of the current one stream.
module circular_arc_sampler #(
  parameter int MAX_POINTS = 64,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_spatial_step,
  input  logic               push,
  output logic               full,
  input  logic [23:0]        in_radius,
  input  logic signed [31:0] in_angular_displacement,
  input  logic signed [31:0] in_angular_offset,
  output logic               empty,
  input  logic               pop,
  output logic signed [24:0] out_point_x,
  output logic signed [24:0] out_point_y,
  output logic [5:0]         out_sample_index,
  output logic               out_last
);
  import cas_pkg::*;

  logic [23:0] step_r;
  logic q_wr, q_full, q_rd, q_empty;
  arc_job_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 24'd6554;
    end else if (cfg_we) begin
      step_r <= cfg_spatial_step;
    end
  end

  cas_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk, .rst_n, .step_cfg(step_r), .in_push(push), .in_full(full),
    .in_radius, .in_angular_displacement, .in_angular_offset,
    .job_push(q_wr), .job_data(q_wdata), .job_full(q_full)
  );

  cas_queue u_queue (
    .clk, .rst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  cas_back #(.MAX_POINTS(MAX_POINTS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk, .rst_n, .job_empty(q_empty), .job_data(q_rdata), .job_pop(q_rd),
    .out_empty(empty), .out_pop(pop), .out_point_x, .out_point_y,
    .out_sample_index, .out_last
  );
endmodule
